// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define LZBD_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("decompressor assertion failed");

// Assertion on the block clock and reset.
`define LZBD_ASSERT(lbl, prop) `LZBD_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

// File: rtl/lzbd_pkg.sv
// Shared types, codes and constants of the block decompressor.
`default_nettype none
package lzbd_pkg;
	localparam int unsigned HISTORY_DEPTH_DEF = 65536;
	localparam logic [31:0] CAPACITY_RST      = 32'd65536;

	localparam logic [2:0] ST_RUNNING   = 3'd0;
	localparam logic [2:0] ST_SUCCESS   = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_CAPACITY  = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_OVERRUN   = 3'd5;
	localparam logic [2:0] ST_BAD_OFF   = 3'd6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_HDR,
		OP_TAG,
		OP_EXT,
		OP_LIT,
		OP_COPY_RD,
		OP_COPY_WR
	} op_t;

	typedef enum logic [1:0] {
		LEN_ZERO,
		LEN_EXP,
		LEN_PROD
	} len_sel_t;

	typedef struct packed {
		op_t        op;
		logic       fin;
		logic [2:0] fin_status;
		len_sel_t   len_sel;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic hdr_end;
		logic hdr_long;
		logic hdr_cap;
		logic hdr_zero;
		logic tag_lit;
		logic tag_ext;
		logic tag_ovr;
		logic ext_last;
		logic ext_lit;
		logic ext_ovr;
		logic copy_bad_off;
		logic copy_ovr;
		logic lit_end;
		logic prod_hit;
		logic copy_end;
	} stat_t;
endpackage
`default_nettype wire

// File: rtl/lzbd_ctrl.sv
// Controller state machine of the block decompressor.
`default_nettype none
module lzbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_last,
	output logic               in_ready,
	input  wire lzbd_pkg::stat_t st,
	output lzbd_pkg::cmd_t     cmd
);
	import lzbd_pkg::*;

	typedef enum logic [2:0] {
		S_HEADER,
		S_TAG,
		S_EXT,
		S_LITERAL,
		S_COPY_RD,
		S_COPY_WR,
		S_DRAIN
	} state_t;

	state_t state_q, state_d;
	logic   last_q, last_d;
	logic   take;

	assign in_ready = st.out_free && (state_q == S_HEADER || state_q == S_TAG ||
		state_q == S_EXT || state_q == S_LITERAL || state_q == S_DRAIN);
	assign take = in_valid && in_ready;

	always_comb begin
		logic lastf;
		lastf   = in_last;
		state_d = state_q;
		last_d  = last_q;
		cmd     = '{op: OP_NONE, fin: 1'b0, fin_status: ST_RUNNING,
			len_sel: LEN_ZERO, clear: 1'b0};
		case (state_q)
			S_HEADER: if (take) begin
				cmd.op = OP_HDR;
				if (st.hdr_end) begin
					if (st.hdr_cap) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_CAPACITY; cmd.len_sel = LEN_EXP;
					end else if (st.hdr_zero) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_SUCCESS;
					end else begin
						state_d = S_TAG;
					end
				end else if (st.hdr_long || lastf) begin
					cmd.fin = 1'b1; cmd.fin_status = ST_BAD_HDR;
				end
			end
			S_TAG: if (take) begin
				cmd.op = OP_TAG;
				if (st.tag_lit && !st.tag_ext) begin
					if (st.tag_ovr) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_OVERRUN; cmd.len_sel = LEN_PROD;
					end else begin
						state_d = S_LITERAL;
					end
				end else begin
					state_d = S_EXT;
				end
			end
			S_EXT: if (take) begin
				cmd.op = OP_EXT;
				if (st.ext_last) begin
					if (st.ext_lit) begin
						if (st.ext_ovr) begin
							cmd.fin = 1'b1; cmd.fin_status = ST_OVERRUN; cmd.len_sel = LEN_PROD;
						end else begin
							state_d = S_LITERAL;
						end
					end else if (st.copy_bad_off) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_BAD_OFF; cmd.len_sel = LEN_PROD;
					end else if (st.copy_ovr) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_OVERRUN; cmd.len_sel = LEN_PROD;
					end else begin
						state_d = S_COPY_RD;
						last_d  = lastf;
					end
				end
			end
			S_LITERAL: if (take) begin
				cmd.op = OP_LIT;
				if (st.lit_end) begin
					state_d = S_TAG;
					if (st.prod_hit) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_SUCCESS; cmd.len_sel = LEN_PROD;
					end
				end
			end
			S_COPY_RD: begin
				cmd.op  = OP_COPY_RD;
				state_d = S_COPY_WR;
			end
			S_COPY_WR: if (st.out_free) begin
				cmd.op  = OP_COPY_WR;
				lastf   = last_q;
				state_d = S_COPY_RD;
				if (st.copy_end) begin
					state_d = S_TAG;
					if (st.prod_hit) begin
						cmd.fin = 1'b1; cmd.fin_status = ST_SUCCESS; cmd.len_sel = LEN_PROD;
					end
				end
			end
			S_DRAIN: if (take && lastf) begin
				cmd.clear = 1'b1;
				state_d   = S_HEADER;
			end
			default: state_d = S_HEADER;
		endcase

		// truncated stream: last byte while incomplete; a copy carries it to its final byte
		if (!cmd.fin && lastf && (take || cmd.op == OP_COPY_WR) && state_d != S_COPY_RD &&
			state_q != S_DRAIN && (state_q != S_COPY_WR || st.copy_end)) begin
			cmd.fin = 1'b1; cmd.fin_status = ST_TRUNCATED; cmd.len_sel = LEN_PROD;
		end
		if (cmd.fin) begin
			cmd.clear = lastf;
			state_d   = lastf ? S_HEADER : S_DRAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HEADER;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end
endmodule
`default_nettype wire

// File: rtl/lzbd_dp.sv
// Datapath of the block decompressor: stream registers, history memory, output register.
`default_nettype none
module lzbd_dp #(
	parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     in_byte,
	input  wire logic           cfg_valid,
	input  wire logic [31:0]    cfg_data,
	input  wire lzbd_pkg::cmd_t cmd,
	output lzbd_pkg::stat_t     st,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_is_data,
	output logic                out_last,
	output logic [2:0]          out_status,
	output logic [31:0]         out_length
);
	import lzbd_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW-1:0] PTR_MAX = AW'(HISTORY_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X = (AW+1)'(HISTORY_DEPTH);

	logic [7:0]    mem [HISTORY_DEPTH];
	logic [31:0]   cap_q, varint_q, exp_q, prod_q, off_q;
	logic [2:0]    shift_q, extra_q;
	logic [32:0]   lit_left_q;
	logic [7:0]    tag_q, rd_q;
	logic [6:0]    copy_left_q;
	logic [AW-1:0] wptr_q, rptr_q;

	logic [4:0]    vshift;
	logic [31:0]   acc_next, off_next, copy_off;
	logic [5:0]    n;
	logic [6:0]    copy_len;
	logic [AW:0]   wext, offt, rstart;
	logic          wr_en, emit;
	logic [7:0]    wr_byte;

	assign vshift   = 5'({2'b00, shift_q} * 5'd7);
	assign acc_next = varint_q | ({25'd0, in_byte[6:0]} << vshift);
	assign off_next = off_q | ({24'd0, in_byte} << {shift_q[1:0], 3'b000});
	assign n        = in_byte[7:2];
	assign copy_len = (tag_q[1:0] == 2'd1) ? 7'd4 + {4'd0, tag_q[4:2]} : 7'd1 + {1'b0, tag_q[7:2]};
	assign copy_off = (tag_q[1:0] == 2'd1) ? {21'd0, tag_q[7:5], off_next[7:0]} : off_next;
	assign wext     = {1'b0, wptr_q};
	assign offt     = copy_off[AW:0];
	assign rstart   = (wext >= offt) ? wext - offt : wext + DEPTH_X - offt;

	always_comb begin
		st.out_free     = !out_valid || out_ready;
		st.hdr_end      = !in_byte[7];
		st.hdr_long     = (shift_q == 3'd4);
		st.hdr_cap      = acc_next > cap_q;
		st.hdr_zero     = (acc_next == 32'd0);
		st.tag_lit      = (in_byte[1:0] == 2'd0);
		st.tag_ext      = (n >= 6'd60);
		st.tag_ovr      = ({2'b00, prod_q} + {28'd0, n} + 34'd1) > {2'b00, exp_q};
		st.ext_last     = (extra_q <= 3'd1);
		st.ext_lit      = (tag_q[1:0] == 2'd0);
		st.ext_ovr      = ({2'b00, prod_q} + {2'b00, off_next} + 34'd1) > {2'b00, exp_q};
		st.copy_bad_off = (copy_off == 32'd0) || (copy_off > prod_q) ||
			({1'b0, copy_off} > 33'(HISTORY_DEPTH));
		st.copy_ovr     = ({1'b0, prod_q} + {26'd0, copy_len}) > {1'b0, exp_q};
		st.lit_end      = (lit_left_q == 33'd1);
		st.prod_hit     = ({1'b0, prod_q} + 33'd1) == {1'b0, exp_q};
		st.copy_end     = (copy_left_q == 7'd1);
	end

	assign wr_en   = (cmd.op == OP_LIT) || (cmd.op == OP_COPY_WR);
	assign wr_byte = (cmd.op == OP_LIT) ? in_byte : rd_q;
	assign emit    = wr_en || cmd.fin;

	// history memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wptr_q] <= wr_byte;
		if (cmd.op == OP_COPY_RD) rd_q <= mem[rptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAPACITY_RST;
			varint_q    <= '0;
			exp_q       <= '0;
			prod_q      <= '0;
			off_q       <= '0;
			shift_q     <= '0;
			extra_q     <= '0;
			lit_left_q  <= '0;
			tag_q       <= '0;
			copy_left_q <= '0;
			wptr_q      <= '0;
			rptr_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_valid) cap_q <= cfg_data;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.clear) begin
				varint_q   <= '0;
				exp_q      <= '0;
				prod_q     <= '0;
				off_q      <= '0;
				shift_q    <= '0;
				extra_q    <= '0;
				lit_left_q <= '0;
				tag_q      <= '0;
				wptr_q     <= '0;
			end else begin
				case (cmd.op)
					OP_HDR: begin
						varint_q <= acc_next;
						exp_q    <= acc_next;
						shift_q  <= shift_q + 3'd1;
					end
					OP_TAG: begin
						tag_q      <= in_byte;
						shift_q    <= '0;
						off_q      <= '0;
						lit_left_q <= {27'd0, n} + 33'd1;
						if (in_byte[1:0] == 2'd0) extra_q <= 3'(n - 6'd59);
						else if (in_byte[1:0] == 2'd1) extra_q <= 3'd1;
						else if (in_byte[1:0] == 2'd2) extra_q <= 3'd2;
						else extra_q <= 3'd4;
					end
					OP_EXT: begin
						off_q       <= off_next;
						shift_q     <= shift_q + 3'd1;
						if (extra_q != 3'd0) extra_q <= extra_q - 3'd1;
						lit_left_q  <= {1'b0, off_next} + 33'd1;
						copy_left_q <= copy_len;
						rptr_q      <= rstart[AW-1:0];
					end
					OP_LIT: begin
						lit_left_q <= lit_left_q - 33'd1;
						prod_q     <= prod_q + 32'd1;
						wptr_q     <= (wptr_q == PTR_MAX) ? '0 : wptr_q + AW'(1);
					end
					OP_COPY_RD: rptr_q <= (rptr_q == PTR_MAX) ? '0 : rptr_q + AW'(1);
					OP_COPY_WR: begin
						copy_left_q <= copy_left_q - 7'd1;
						prod_q      <= prod_q + 32'd1;
						wptr_q      <= (wptr_q == PTR_MAX) ? '0 : wptr_q + AW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte    <= wr_en ? wr_byte : 8'd0;
			out_is_data <= wr_en;
			out_last    <= cmd.fin;
			out_status  <= cmd.fin ? cmd.fin_status : ST_RUNNING;
			case (cmd.len_sel)
				LEN_EXP:  out_length <= cmd.fin ? acc_next : 32'd0;
				LEN_PROD: out_length <= cmd.fin ? prod_q + {31'd0, wr_en} : 32'd0;
				default:  out_length <= 32'd0;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/lz_block_decompressor.sv
// Top level of the raw block decompressor: controller plus datapath.
//
// Channel | Dir | Handshake            | Content
// s_      | in  | s_tvalid / s_tready  | tdata[7:0] in_byte, tlast in_last
// m_      | out | m_tvalid / m_tready  | tdata byte/status/length, tuser is_data, tlast last
// cfg_    | in  | cfg_valid / cfg_ready| out_capacity write, always ready
//
// Header, tag and extension bytes are each taken in one handshake; literal bytes
// pass at one byte per cycle while the output register is free. A copy holds the
// input while each copied byte is read from history, then written back and output.
// The output register is single-entry; a stall on m_tready holds the input too.
// Reset restores capacity 65536 and the header phase; history needs no clearing.
`default_nettype none
module lz_block_decompressor #(
	parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] data_byte, [10:8] status, [42:11] out_length
	output logic             m_tuser,   // [0] is_data
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import lzbd_pkg::*;

	cmd_t        cmd;
	stat_t       st;
	logic [7:0]  o_byte;
	logic [2:0]  o_status;
	logic [31:0] o_len;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	lzbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lzbd_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (o_byte),
		.out_is_data (m_tuser),
		.out_last    (m_tlast),
		.out_status  (o_status),
		.out_length  (o_len)
	);

	// pack result fields, zero fill to whole bytes
	assign m_tdata = {5'd0, o_len, o_status, o_byte};
endmodule
`default_nettype wire

// File: rtl/lzbd_checker.sv
// Port-level checker of the decompressor and its bind.
`default_nettype none
`include "assert_macros.svh"
module lzbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	`LZBD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
	`LZBD_ASSERT(a_status_only_final, m_tvalid && !m_tuser |-> m_tlast)
	`LZBD_ASSERT(a_running_status, m_tvalid && !m_tlast |-> m_tdata[10:8] == 3'd0)
	`LZBD_ASSERT(a_final_status, m_tvalid && m_tlast |-> m_tdata[10:8] != 3'd0)
endmodule

bind lz_block_decompressor lzbd_checker u_lzbd_checker (.*);
`default_nettype wire

// File: test/tb_lz_block_decompressor.sv
// Self-checking testbench for the raw block decompressor.
`default_nettype none
module tb_lz_block_decompressor;
	timeunit 1ns;
	timeprecision 1ps;
	import lzbd_pkg::*;

	localparam int HDEPTH = 65536;

	// phases of the decoder
	typedef enum int {P_HDR, P_TAG, P_LITLEN, P_LIT, P_COPYOFF, P_DRAIN} dec_phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_data;
		logic        last;
		logic [2:0]  status;
		logic [31:0] out_length;
	} out_item_t;

	// directed row: a byte to send, or a capacity write carrying its value in len
	typedef struct packed {
		logic        wr_cfg;
		logic [7:0]  b;
		logic        lastf;
		logic        chk;
		logic [2:0]  st;
		logic [31:0] len;
	} dir_row_t;

	localparam int N_ROWS = 38;
	localparam dir_row_t DIR_ROWS [N_ROWS] = '{
		'{1'b0, 8'h00, 1'b0, 1'b1, ST_SUCCESS,   32'd0},
		'{1'b0, 8'hAA, 1'b1, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h00, 1'b1, 1'b1, ST_SUCCESS,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b1, ST_BAD_HDR,   32'd0},
		'{1'b0, 8'h00, 1'b1, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h81, 1'b1, 1'b1, ST_BAD_HDR,   32'd0},
		'{1'b0, 8'h81, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h80, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h04, 1'b1, 1'b1, ST_CAPACITY,  32'h10001},
		'{1'b0, 8'h04, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h0C, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h02, 1'b1, 1'b1, ST_SUCCESS,   32'd4},
		'{1'b0, 8'h04, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h05, 1'b1, 1'b1, ST_TRUNCATED, 32'd0},
		'{1'b0, 8'h02, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h08, 1'b1, 1'b1, ST_OVERRUN,   32'd0},
		'{1'b0, 8'h08, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h5A, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h01, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h05, 1'b1, 1'b1, ST_BAD_OFF,   32'd1},
		'{1'b1, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'h01, 1'b1, 1'b1, ST_CAPACITY,  32'd1},
		'{1'b1, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'hFFFFFFFF},
		'{1'b0, 8'h03, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFC, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b0, 1'b0, ST_RUNNING,   32'd0},
		'{1'b0, 8'hFF, 1'b1, 1'b1, ST_OVERRUN,   32'd0},
		'{1'b1, 8'h00, 1'b0, 1'b0, ST_RUNNING,   32'd200}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	lz_block_decompressor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] capacity;
	dec_phase_t  ph;
	logic [31:0] vacc, exp_len, prod_len, off_acc;
	logic [32:0] lit_left;
	logic [2:0]  shcnt, extra;
	logic [7:0]  tag;
	logic [7:0]  hist [HDEPTH];
	bit          fin_done;
	out_item_t   step_res[$];

	out_item_t   expected_out[$];
	int          errors = 0;
	bit          hold_off = 0;

	function automatic void clear_stream();
		ph = P_HDR; vacc = 0; shcnt = 0; exp_len = 0; prod_len = 0;
		lit_left = 0; tag = 0; off_acc = 0; extra = 0;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		out_item_t r;
		hist[prod_len % HDEPTH] = b;
		prod_len++;
		r = '0; r.data_byte = b; r.is_data = 1'b1;
		step_res.push_back(r);
	endfunction

	// attach the final status to the last result of this step, or append one
	function automatic void finish_stream(logic [2:0] st, logic [31:0] len, bit lastf);
		out_item_t r;
		if (step_res.size() == 0) begin
			r = '0;
			step_res.push_back(r);
		end
		r = step_res[$];
		r.last = 1'b1; r.status = st; r.out_length = len;
		step_res[step_res.size()-1] = r;
		fin_done = 1;
		if (lastf) clear_stream();
		else ph = P_DRAIN;
	endfunction

	function automatic void start_literal(logic [32:0] len, bit lastf);
		if ({1'b0, prod_len} + len > {1'b0, exp_len}) finish_stream(ST_OVERRUN, prod_len, lastf);
		else begin
			lit_left = len; ph = P_LIT;
		end
	endfunction

	function automatic void run_copy(bit lastf);
		logic [32:0] len, offs;
		if (tag[1:0] == 2'd1) begin
			len = 4 + tag[4:2];
			offs = {22'd0, tag[7:5], off_acc[7:0]};
		end else begin
			len = 1 + tag[7:2];
			offs = {1'b0, off_acc};
		end
		if (offs == 0 || offs > prod_len || offs > HDEPTH) begin
			finish_stream(ST_BAD_OFF, prod_len, lastf);
			return;
		end
		if ({1'b0, prod_len} + len > {1'b0, exp_len}) begin
			finish_stream(ST_OVERRUN, prod_len, lastf);
			return;
		end
		for (int i = 0; i < len; i++) put_byte(hist[(prod_len - offs[31:0]) % HDEPTH]);
		ph = P_TAG;
		if (prod_len == exp_len) finish_stream(ST_SUCCESS, prod_len, lastf);
	endfunction

	// advance the decoder model by one compressed byte
	function automatic void decode_byte(logic [7:0] b, bit lastf);
		logic [5:0] n;
		step_res.delete();
		fin_done = 0;
		case (ph)
			P_HDR: begin
				vacc |= {25'd0, b[6:0]} << ((7 * shcnt) & 31);
				if (!b[7]) begin
					exp_len = vacc;
					if (exp_len > capacity) finish_stream(ST_CAPACITY, exp_len, lastf);
					else if (exp_len == 0) finish_stream(ST_SUCCESS, 0, lastf);
					else ph = P_TAG;
				end else begin
					shcnt++;
					if (shcnt >= 5 || lastf) finish_stream(ST_BAD_HDR, 0, lastf);
				end
			end
			P_TAG: begin
				tag = b; shcnt = 0; off_acc = 0; n = b[7:2];
				if (b[1:0] == 2'd0) begin
					if (n < 60) start_literal(n + 1, lastf);
					else begin
						extra = n - 59; ph = P_LITLEN;
					end
				end else begin
					extra = (b[1:0] == 2'd1) ? 1 : (b[1:0] == 2'd2 ? 2 : 4);
					ph = P_COPYOFF;
				end
			end
			P_LITLEN, P_COPYOFF: begin
				off_acc |= {24'd0, b} << (8 * shcnt[1:0]);
				shcnt++;
				if (extra > 0) extra--;
				if (extra == 0) begin
					if (ph == P_LITLEN) start_literal({1'b0, off_acc} + 1, lastf);
					else run_copy(lastf);
				end
			end
			P_LIT: begin
				put_byte(b);
				if (lit_left > 0) lit_left--;
				if (lit_left == 0) begin
					ph = P_TAG;
					if (prod_len == exp_len) finish_stream(ST_SUCCESS, prod_len, lastf);
				end
			end
			default: begin
				if (lastf) clear_stream();
				return;
			end
		endcase
		if (!fin_done && lastf) finish_stream(ST_TRUNCATED, prod_len, lastf);
	endfunction

	// send one compressed byte and queue what it should produce; valid stays up
	// after the transaction unless a gap or an idle phase follows
	task automatic send_byte(logic [7:0] b, bit lastf);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1; s_tdata <= b; s_tlast <= lastf;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b, lastf);
		foreach (step_res[i]) expected_out.push_back(step_res[i]);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_capacity(logic [31:0] v);
		wait_idle();
		cfg_valid <= 1'b1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		capacity = v;
	endtask

	task automatic send_varint(logic [31:0] v);
		while (v >= 128) begin
			send_byte({1'b1, v[6:0]}, 1'b0);
			v = v >> 7;
		end
		send_byte(v[7:0], 1'b0);
	endtask

	// one well-formed stream with random literals and copies, sometimes broken
	task automatic send_stream();
		int total, done, k, len, offs, mode;
		total = $urandom_range(1, 40);
		mode = $urandom_range(0, 9);
		done = 0;
		send_varint(32'(total));
		while (done < total) begin
			if (mode == 0 && $urandom_range(0, 7) == 0) begin
				send_byte(8'($urandom), 1'b1);
				return;
			end
			if (done == 0 || $urandom_range(0, 1) == 0) begin
				len = $urandom_range(1, (total - done) < 20 ? total - done : 20);
				if ($urandom_range(0, 3) == 0) begin
					send_byte(8'hF0, 1'b0); send_byte(8'(len - 1), 1'b0);
				end else send_byte(8'((len - 1) << 2), 1'b0);
				for (k = 0; k < len; k++) send_byte(8'($urandom), done + k + 1 == total);
			end else begin
				len = $urandom_range(1, (total - done) < 11 ? total - done : 11);
				offs = $urandom_range(1, done);
				if (mode == 1) offs = done + 1;
				if (len >= 4 && $urandom_range(0, 1)) begin
					send_byte({offs[10:8], len[2:0] - 3'd4, 2'b01}, 1'b0);
					send_byte(offs[7:0], done + len == total);
				end else begin
					send_byte({len[5:0] - 6'd1, 2'b10}, 1'b0);
					send_byte(offs[7:0], 1'b0);
					send_byte(offs[15:8], done + len == total);
				end
				if (mode == 1) return;
			end
			done += len;
		end
	endtask

	// result checker with random stalls
	initial begin
		out_item_t got, want;
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.data_byte = m_tdata[7:0];
				got.status = m_tdata[10:8];
				got.out_length = m_tdata[42:11];
				got.is_data = m_tuser;
				got.last = m_tlast;
				if (expected_out.size() == 0) begin
					$display("%0t unexpected result: %h", $realtime, got);
					errors++;
				end else begin
					want = expected_out.pop_front();
					if (!got.is_data) got.data_byte = 8'd0;
					if (got != want)
						$display("%0t mismatch: expected %h actual %h", $realtime, want, got);
					if (got != want) errors++;
				end
			end
		end
	end

	initial begin
		out_item_t row_res;
		capacity = CAPACITY_RST;
		clear_stream();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero length, header extremes, capacity, truncation, offsets, overrun
		foreach (DIR_ROWS[r]) begin
			if (DIR_ROWS[r].wr_cfg) write_capacity(DIR_ROWS[r].len);
			else begin
				send_byte(DIR_ROWS[r].b, DIR_ROWS[r].lastf);
				if (DIR_ROWS[r].chk) begin
					row_res = '0;
					if (step_res.size() != 0) row_res = step_res[$];
					if (!row_res.last || row_res.status != DIR_ROWS[r].st ||
						row_res.out_length != DIR_ROWS[r].len) begin
						$display("%0t directed row %0d: expected status %0d len %0d actual %0d len %0d",
							$realtime, r, DIR_ROWS[r].st, DIR_ROWS[r].len,
							row_res.status, row_res.out_length);
						errors++;
					end
				end
			end
		end
		// random streams; one with a long receiver hold-off
		for (int s = 0; s < 10; s++) begin
			if (s == 4) hold_off = 1;
			send_stream();
			if (s == 7) wait_idle();
		end
		for (int k = 0; k < 15; k++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		write_capacity(32'd65536);
		for (int s = 0; s < 4; s++) send_stream();
		wait_idle();
		if (errors == 0) $display("** lz_block_decompressor: PASSED **");
		else $display("** lz_block_decompressor: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** lz_block_decompressor: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
